// File: hw/rtl/gdc_pkg.sv
// ----------------------------------------------------------------------------
// gdc_pkg: shared definitions for the gregorian date counter
// Command codes, field widths, calendar constants and the leap-year and
// month-length helpers.
// ----------------------------------------------------------------------------
package gdc_pkg;

	// field widths
	localparam int unsigned CMD_W   = 2;
	localparam int unsigned MONTH_W = 4;
	localparam int unsigned DAY_W   = 5;
	localparam int unsigned YEAR_W  = 16;

	// packed stream widths, rounded up to whole bytes
	localparam int unsigned IN_W     = MONTH_W + DAY_W + YEAR_W;
	localparam int unsigned IN_BYTES = (IN_W + 7) / 8;
	localparam int unsigned OUT_W    = MONTH_W + DAY_W + YEAR_W + 1 + DAY_W;
	localparam int unsigned OUT_BYTES = (OUT_W + 7) / 8;

	typedef logic [CMD_W-1:0]   cmd_t;
	typedef logic [MONTH_W-1:0] month_t;
	typedef logic [DAY_W-1:0]   day_t;
	typedef logic [YEAR_W-1:0]  year_t;

	// command codes
	localparam cmd_t CMD_LOAD = 2'd0;
	localparam cmd_t CMD_NEXT = 2'd1;
	localparam cmd_t CMD_PREV = 2'd2;

	// calendar constants
	localparam year_t  BASE_YEAR = 16'd1900;
	localparam month_t JANUARY   = 4'd1;
	localparam month_t FEBRUARY  = 4'd2;
	localparam month_t DECEMBER  = 4'd12;
	localparam day_t   FIRST_DAY = 5'd1;

	// divisibility by 25: multiply by the inverse of 25 modulo 2^16,
	// the product is small exactly for multiples of 25
	localparam year_t INV25     = 16'd23593;
	localparam year_t DIV25_MAX = 16'd2621;

	// divisible by 4 and not by 100, or divisible by 400
	function automatic logic is_leap(input year_t year);
		year_t prod;
		logic  div25;
		prod  = year * INV25;
		div25 = (prod <= DIV25_MAX);
		return (year[1:0] == 2'd0) && (!div25 || (year[3:0] == 4'd0));
	endfunction

	// days in a month, month assumed in 1..12
	function automatic day_t month_len(input month_t month, input logic leap);
		day_t len;
		if (month inside {4'd4, 4'd6, 4'd9, 4'd11}) begin
			len = 5'd30;
		end else if (month == FEBRUARY) begin
			len = leap ? 5'd29 : 5'd28;
		end else begin
			len = 5'd31;
		end
		return len;
	endfunction

endpackage

// File: hw/rtl/gregorian_date_counter.sv
// ----------------------------------------------------------------------------
// gregorian_date_counter: calendar date register with load and day stepping
// A request accepted at one clock edge shows its result on m_t* from the next
// cycle on. One request per cycle while the sink takes each report; the output
// register refills in the cycle it is taken, so s_tready stays high under
// a full-rate sink. Reset puts the date at January 1 of 1900, non-leap,
// and empties the output register.
// ----------------------------------------------------------------------------
module gregorian_date_counter (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// month_in[3:0], day_in[8:4], year_in[24:9], zero fill
	input  logic [gdc_pkg::IN_BYTES*8-1:0]  s_tdata,
	// cmd[1:0]
	input  logic [gdc_pkg::CMD_W-1:0]       s_tuser,
	output logic        m_tvalid,
	input  logic        m_tready,
	// month_out[3:0], day_out[8:4], year_out[24:9], leap_year[25],
	// month_length[30:26], zero fill
	output logic [gdc_pkg::OUT_BYTES*8-1:0] m_tdata
);

	// current date and leap flag of the current year
	gdc_pkg::month_t month_q;
	gdc_pkg::day_t   day_q;
	gdc_pkg::year_t  year_q;
	logic            leap_q;

	// output register
	logic                           out_valid_q;
	logic [gdc_pkg::OUT_W-1:0]      out_data_q;

	// request fields
	gdc_pkg::cmd_t   cmd;
	gdc_pkg::month_t month_in;
	gdc_pkg::day_t   day_in;
	gdc_pkg::year_t  year_in;

	// next state
	gdc_pkg::month_t month_nx;
	gdc_pkg::day_t   day_nx;
	gdc_pkg::year_t  year_nx;
	logic            leap_nx;
	gdc_pkg::day_t   len_nx;
	gdc_pkg::day_t   len_cur;
	logic            accept;

	assign cmd      = s_tuser;
	assign month_in = s_tdata[3:0];
	assign day_in   = s_tdata[8:4];
	assign year_in  = s_tdata[24:9];

	assign s_tready = !out_valid_q || m_tready;
	assign accept   = s_tvalid && s_tready;

	assign len_cur = gdc_pkg::month_len(month_q, leap_q);

	// month and year of the new date
	always_comb begin
		month_nx = month_q;
		year_nx  = year_q;
		case (cmd)
			gdc_pkg::CMD_LOAD: begin
				year_nx  = (year_in != '0) ? year_in : gdc_pkg::BASE_YEAR;
				month_nx = (month_in inside {[4'd1:4'd12]}) ? month_in
				                                             : gdc_pkg::JANUARY;
			end
			gdc_pkg::CMD_NEXT: begin
				if (day_q >= len_cur) begin
					if (month_q >= gdc_pkg::DECEMBER) begin
						month_nx = gdc_pkg::JANUARY;
						year_nx  = year_q + 16'd1;
					end else begin
						month_nx = month_q + 4'd1;
					end
				end
			end
			gdc_pkg::CMD_PREV: begin
				if (day_q <= gdc_pkg::FIRST_DAY) begin
					if (month_q <= gdc_pkg::JANUARY) begin
						month_nx = gdc_pkg::DECEMBER;
						year_nx  = year_q - 16'd1;
					end else begin
						month_nx = month_q - 4'd1;
					end
				end
			end
			default: begin
				month_nx = month_q;
				year_nx  = year_q;
			end
		endcase
	end

	// leap flag and month length of the new date
	assign leap_nx = gdc_pkg::is_leap(year_nx);
	assign len_nx  = gdc_pkg::month_len(month_nx, leap_nx);

	// day of the new date
	always_comb begin
		day_nx = day_q;
		case (cmd)
			gdc_pkg::CMD_LOAD: begin
				day_nx = ((day_in >= gdc_pkg::FIRST_DAY) && (day_in <= len_nx))
				         ? day_in : gdc_pkg::FIRST_DAY;
			end
			gdc_pkg::CMD_NEXT: begin
				day_nx = (day_q >= len_cur) ? gdc_pkg::FIRST_DAY : day_q + 5'd1;
			end
			gdc_pkg::CMD_PREV: begin
				day_nx = (day_q <= gdc_pkg::FIRST_DAY) ? len_nx : day_q - 5'd1;
			end
			default: begin
				day_nx = day_q;
			end
		endcase
	end

	// date state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			month_q <= gdc_pkg::JANUARY;
			day_q   <= gdc_pkg::FIRST_DAY;
			year_q  <= gdc_pkg::BASE_YEAR;
			leap_q  <= 1'b0;
		end else if (accept) begin
			month_q <= month_nx;
			day_q   <= day_nx;
			year_q  <= year_nx;
			leap_q  <= leap_nx;
		end
	end

	// output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	// output payload
	always_ff @(posedge clk) begin
		if (accept) begin
			out_data_q <= {len_nx, leap_nx, year_nx, day_nx, month_nx};
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {{(gdc_pkg::OUT_BYTES*8 - gdc_pkg::OUT_W){1'b0}}, out_data_q};

endmodule

// File: dv/tb_gregorian_date_counter.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_gregorian_date_counter: self-checking bench for the date counter
// Drives load, advance and go-back requests over the s_t* stream, keeps its
// own copy of the calendar date to predict every report on m_t*, and checks
// each report field by field. Idle and stall rates change phase by phase,
// and one long receiver hold-off backs up the block.
// ----------------------------------------------------------------------------
module tb_gregorian_date_counter;
	import gdc_pkg::*;

	// command code the block holds on
	localparam cmd_t CMD_HOLD        = 2'd3;
	localparam int   CYCLE_LIMIT     = 200000;
	localparam int   HOLD_OFF_CYCLES = 300;
	localparam int   PHASE_ITEMS     = 250;
	localparam int   MAX_SHOWN       = 10;

	typedef struct {
		month_t month;
		day_t   day;
		year_t  year;
		logic   leap;
		day_t   len;
	} date_report_t;

	// calendar tracker and queue of reports still to come
	class date_scoreboard;
		month_t       cur_month;
		day_t         cur_day;
		year_t        cur_year;
		date_report_t reports_due[$];
		int mismatches, n_checked, n_load, n_fixed, n_next, n_prev, n_hold, n_wrap;

		function new();
			cur_month  = JANUARY;
			cur_day    = FIRST_DAY;
			cur_year   = BASE_YEAR;
			mismatches = 0;
			n_checked  = 0;
			n_load     = 0;
			n_fixed    = 0;
			n_next     = 0;
			n_prev     = 0;
			n_hold     = 0;
			n_wrap     = 0;
		endfunction

		function bit is_leap_year(year_t y);
			return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
		endfunction

		function day_t days_in(month_t m, year_t y);
			case (m)
				4'd4, 4'd6, 4'd9, 4'd11: return 5'd30;
				FEBRUARY: return is_leap_year(y) ? 5'd29 : 5'd28;
				default: return 5'd31;
			endcase
		endfunction

		function string show(date_report_t r);
			return $sformatf("%0d-%0d-%0d leap=%0d len=%0d",
				r.year, r.month, r.day, r.leap, r.len);
		endfunction

		// accepted request: step the date and queue the report it causes
		function void note_request(cmd_t c, month_t m, day_t d, year_t y);
			date_report_t r;
			case (c)
				CMD_LOAD: begin
					n_load++;
					cur_year  = (y != 0) ? y : BASE_YEAR;
					cur_month = (m >= JANUARY && m <= DECEMBER) ? m : JANUARY;
					cur_day   = (d >= FIRST_DAY && d <= days_in(cur_month, cur_year)) ?
						d : FIRST_DAY;
					if (cur_year != y || cur_month != m || cur_day != d)
						n_fixed++;
				end
				CMD_NEXT: begin
					n_next++;
					if (cur_day >= days_in(cur_month, cur_year)) begin
						cur_day = FIRST_DAY;
						if (cur_month >= DECEMBER) begin
							cur_month = JANUARY;
							cur_year  = cur_year + 16'd1;
							if (cur_year == 0)
								n_wrap++;
						end else begin
							cur_month = cur_month + 4'd1;
						end
					end else begin
						cur_day = cur_day + 5'd1;
					end
				end
				CMD_PREV: begin
					n_prev++;
					if (cur_day <= FIRST_DAY) begin
						if (cur_month <= JANUARY) begin
							cur_month = DECEMBER;
							if (cur_year == 0)
								n_wrap++;
							cur_year = cur_year - 16'd1;
						end else begin
							cur_month = cur_month - 4'd1;
						end
						cur_day = days_in(cur_month, cur_year);
					end else begin
						cur_day = cur_day - 5'd1;
					end
				end
				default: begin
					n_hold++;
				end
			endcase
			r.month = cur_month;
			r.day   = cur_day;
			r.year  = cur_year;
			r.leap  = is_leap_year(cur_year);
			r.len   = days_in(cur_month, cur_year);
			reports_due.push_back(r);
		endfunction

		// accepted report: compare with the oldest one due
		function void check_result(logic [OUT_BYTES*8-1:0] data);
			date_report_t want, got;
			got.month = data[3:0];
			got.day   = data[8:4];
			got.year  = data[24:9];
			got.leap  = data[25];
			got.len   = data[30:26];
			if (reports_due.size() == 0) begin
				mismatches++;
				if (mismatches <= MAX_SHOWN)
					$display("[sb] report with nothing due: %s", show(got));
				return;
			end
			want = reports_due.pop_front();
			n_checked++;
			if (got.month !== want.month || got.day !== want.day ||
			    got.year !== want.year || got.leap !== want.leap ||
			    got.len !== want.len) begin
				mismatches++;
				if (mismatches <= MAX_SHOWN)
					$display("[sb] report %0d: expected %s, got %s",
						n_checked, show(want), show(got));
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;
	logic s_tvalid;
	logic s_tready;
	logic [IN_BYTES*8-1:0] s_tdata;
	logic [CMD_W-1:0] s_tuser;
	logic m_tvalid;
	logic m_tready;
	logic [OUT_BYTES*8-1:0] m_tdata;

	int send_idle    = 0;
	int recv_stall   = 0;
	int hold_off_len = 0;
	int cycle_count  = 0;

	date_scoreboard sb = new();

	gregorian_date_counter dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always #5 clk = ~clk;

	// watch both handshakes
	always @(posedge clk) begin
		if (s_tvalid && s_tready)
			sb.note_request(s_tuser, s_tdata[3:0], s_tdata[8:4], s_tdata[24:9]);
		if (m_tvalid && m_tready)
			sb.check_result(m_tdata);
	end

	// run limit
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("[tb] timeout after %0d cycles, %0d reports still due",
				cycle_count, sb.reports_due.size());
			$display("gregorian_date_counter: mismatch");
			$finish;
		end
	end

	// receiver: random stalls, plus a long hold-off on request
	initial begin
		int hold_left;
		hold_left = 0;
		m_tready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_off_len != 0) begin
				hold_left    = hold_off_len;
				hold_off_len = 0;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= ($urandom_range(99) >= recv_stall);
			end
		end
	end

	// offer one request and wait until it is taken
	task automatic send_request(cmd_t c, month_t m, day_t d, year_t y);
		while ($urandom_range(99) < send_idle) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= c;
		s_tdata  <= {{(IN_BYTES*8-IN_W){1'b0}}, y, d, m};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
	endtask

	// a load, often near a month or year edge, and a run of steps, or one raw request
	task automatic random_burst(output int n);
		int     steps, fwd_pct;
		month_t m;
		day_t   d;
		year_t  y;
		cmd_t   c;
		if ($urandom_range(99) < 10) begin
			send_request(cmd_t'($urandom_range(3)), month_t'($urandom_range(15)),
				day_t'($urandom_range(31)), year_t'($urandom_range(65535)));
			n = 1;
		end else begin
			m = month_t'($urandom_range(12, 1));
			if ($urandom_range(3) == 0)
				m = $urandom_range(1) ? DECEMBER : JANUARY;
			case ($urandom_range(5))
				0: y = 16'd0;
				1: y = 16'hFFFF;
				2: y = year_t'(100 * $urandom_range(655));
				3: y = year_t'(4 * $urandom_range(16383));
				default: y = year_t'($urandom_range(65535));
			endcase
			case ($urandom_range(4))
				0: d = FIRST_DAY;
				1: d = sb.days_in(m, y);
				2: d = sb.days_in(m, y) - 5'd1;
				3: d = 5'd2;
				default: d = day_t'($urandom_range(sb.days_in(m, y), 1));
			endcase
			send_request(CMD_LOAD, m, d, y);
			steps   = $urandom_range(8, 1);
			fwd_pct = $urandom_range(100);
			repeat (steps) begin
				if ($urandom_range(99) < 3)
					c = CMD_HOLD;
				else
					c = ($urandom_range(99) < fwd_pct) ? CMD_NEXT : CMD_PREV;
				send_request(c, month_t'($urandom), day_t'($urandom), year_t'($urandom));
			end
			n = steps + 1;
		end
	endtask

	task automatic random_phase(int idle_pct, int stall_pct);
		int sent, n;
		send_idle  = idle_pct;
		recv_stall = stall_pct;
		sent = 0;
		while (sent < PHASE_ITEMS) begin
			random_burst(n);
			sent += n;
		end
	endtask

	initial begin
		int n, sent;
		arst_n   <= 1'b0;
		s_tvalid <= 1'b0;
		s_tdata  <= '0;
		s_tuser  <= CMD_LOAD;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: field extremes, corrections and rollovers
		send_request(CMD_HOLD, 4'd0, 5'd0, 16'd0);
		send_request(CMD_PREV, 4'd0, 5'd0, 16'd0);
		send_request(CMD_NEXT, 4'hF, 5'h1F, 16'hFFFF);
		send_request(CMD_LOAD, 4'd0, 5'd0, 16'd0);
		send_request(CMD_LOAD, 4'hF, 5'h1F, 16'hFFFF);
		send_request(CMD_LOAD, FEBRUARY, 5'd29, 16'd1900);
		send_request(CMD_LOAD, FEBRUARY, 5'd29, 16'd2000);
		send_request(CMD_LOAD, FEBRUARY, 5'd29, 16'd2024);
		send_request(CMD_NEXT, 4'd0, 5'd0, 16'd0);
		send_request(CMD_LOAD, 4'd4, 5'd31, 16'd2023);
		send_request(CMD_LOAD, DECEMBER, 5'd31, 16'hFFFF);
		send_request(CMD_NEXT, 4'd0, 5'd0, 16'd0);
		send_request(CMD_PREV, 4'd0, 5'd0, 16'd0);
		send_request(CMD_LOAD, 4'd3, FIRST_DAY, 16'd2024);
		send_request(CMD_PREV, 4'd0, 5'd0, 16'd0);
		send_request(CMD_LOAD, 4'd3, FIRST_DAY, 16'd2023);
		send_request(CMD_PREV, 4'd0, 5'd0, 16'd0);
		send_request(CMD_LOAD, 4'd8, FIRST_DAY, 16'd2023);
		send_request(CMD_PREV, 4'd0, 5'd0, 16'd0);
		send_request(CMD_LOAD, 4'd5, FIRST_DAY, 16'd2023);
		send_request(CMD_PREV, 4'd0, 5'd0, 16'd0);
		send_request(CMD_LOAD, JANUARY, 5'd31, 16'd1);
		send_request(CMD_NEXT, 4'd0, 5'd0, 16'd0);
		send_request(CMD_HOLD, 4'hF, 5'h1F, 16'hFFFF);

		// random phases with different idle and stall rates
		random_phase(0, 0);
		random_phase(54, 0);
		random_phase(0, 54);
		random_phase(13, 13);

		// long receiver hold-off while the sender keeps offering
		send_idle    = 0;
		recv_stall   = 0;
		hold_off_len = HOLD_OFF_CYCLES;
		sent = 0;
		while (sent < 30) begin
			random_burst(n);
			sent += n;
		end
		s_tvalid <= 1'b0;

		// drain
		while (sb.reports_due.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);

		$display("[tb] %0d checked: %0d loads (%0d fixed), %0d next, %0d back, %0d holds",
			sb.n_checked, sb.n_load, sb.n_fixed, sb.n_next, sb.n_prev, sb.n_hold);
		$display("[tb] %0d year wraps; idle: none, sender, receiver, both; %0d-cycle hold-off",
			sb.n_wrap, HOLD_OFF_CYCLES);
		if (sb.mismatches == 0 && sb.reports_due.size() == 0)
			$display("gregorian_date_counter: match");
		else
			$display("gregorian_date_counter: mismatch");
		$finish;
	end

endmodule
